FILE: hw/rtl/ntt_limb_multiplier_defines.svh
// assertion macros for the ntt limb multiplier
`ifndef NTT_LIMB_MULTIPLIER_DEFINES_SVH
`define NTT_LIMB_MULTIPLIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define NLM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define NLM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define NLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NLM_ASSERT(label, expr, msg)
`define NLM_ASSERT_IMPL(label, ante, cons, msg)
`define NLM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/nlm_pkg.sv
// shared constants, types, root tables and command structs of the ntt limb multiplier
package nlm_pkg;

    localparam int N         = 64;
    localparam int LOG_N     = $clog2(N);
    localparam int ADDR_W    = LOG_N;
    localparam int CNT_W     = LOG_N + 1;
    localparam int BF_W      = LOG_N - 1;
    localparam int STG_W     = $clog2(LOG_N);
    localparam int COEF_W    = 30;
    localparam int LIMB_W    = 12;
    localparam int CARRY_W   = 20;
    localparam int ACC_W     = COEF_W + 1 - LIMB_W;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int MU_W      = COEF_W + 1;
    localparam int R_W       = 32;

    localparam logic [31:0] MODULUS   = 32'd998244353;
    localparam logic [31:0] GENERATOR = 32'd3;

    typedef logic [COEF_W-1:0] coef_t;
    typedef coef_t root_tab_t [N];

    // elaboration-time modular helpers
    function automatic logic [31:0] mod_mul_c(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = (64'(a) * 64'(b)) % 64'(MODULUS);
        return p[31:0];
    endfunction

    function automatic logic [31:0] mod_pow_c(input logic [31:0] base, input logic [31:0] e);
        logic [31:0] r;
        logic [31:0] b;
        r = 32'd1;
        b = 32'(64'(base) % 64'(MODULUS));
        for (int k = 0; k < 32; k++)
        begin
            if (e[k])
            begin
                r = mod_mul_c(r, b);
            end
            b = mod_mul_c(b, b);
        end
        return r;
    endfunction

    function automatic root_tab_t make_roots(input logic inverse);
        root_tab_t   tab;
        logic [31:0] w;
        logic [31:0] cur;
        w = mod_pow_c(GENERATOR, (MODULUS - 32'd1) / N);
        if (inverse)
        begin
            w = mod_pow_c(w, MODULUS - 32'd2);
        end
        cur = 32'd1;
        for (int k = 0; k < N; k++)
        begin
            tab[k] = cur[COEF_W-1:0];
            cur = mod_mul_c(cur, w);
        end
        return tab;
    endfunction

    localparam root_tab_t FWD_ROOTS = make_roots(1'b0);
    localparam root_tab_t INV_ROOTS = make_roots(1'b1);

    localparam logic [31:0] NINV_WIDE = mod_pow_c(32'(N), MODULUS - 32'd2);
    localparam coef_t       NINV      = NINV_WIDE[COEF_W-1:0];

    // barrett reciprocal floor(2^(2*COEF_W) / Q)
    localparam logic [63:0]     MU_WIDE = (64'd1 << PROD_W) / 64'(MODULUS);
    localparam logic [MU_W-1:0] MU      = MU_WIDE[MU_W-1:0];

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] x);
        logic [ADDR_W-1:0] r;
        for (int k = 0; k < ADDR_W; k++)
        begin
            r[k] = x[ADDR_W-1-k];
        end
        return r;
    endfunction

    // write data source of the coefficient stores
    typedef enum logic [1:0] {
        WSRC_LOAD = 2'd0,
        WSRC_ZERO = 2'd1,
        WSRC_SUM  = 2'd2,
        WSRC_MUL  = 2'd3
    } wsrc_t;

    // operand pair of the modular multiplier
    typedef enum logic [1:0] {
        MOP_BFLY  = 2'd0,
        MOP_POINT = 2'd1,
        MOP_SCALE = 2'd2
    } mop_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
        logic              sel_b;
        logic              we_a;
        logic              we_b;
        logic [ADDR_W-1:0] wr_addr;
        wsrc_t             wr_src;
        logic              bf_latch;
        logic              mul_start;
        mop_t              mul_op;
        logic [ADDR_W-1:0] tw_idx;
        logic              tw_inv;
        logic              emit;
        logic              emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
    } dp_stat_t;

endpackage

FILE: hw/rtl/nlm_modmul.sv
// pipelined barrett modular multiplier; done is start carried down the valid pipeline
module nlm_modmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  nlm_pkg::coef_t x,
    input  nlm_pkg::coef_t y,
    output logic          done,
    output nlm_pkg::coef_t res
);

    logic [4:0]                       vld_reg;
    logic [nlm_pkg::PROD_W-1:0]       p_reg;
    logic [2*nlm_pkg::MU_W-1:0]       t_reg;
    logic [nlm_pkg::R_W-1:0]          p2_reg;
    logic [nlm_pkg::R_W-1:0]          p3_reg;
    logic [nlm_pkg::R_W-1:0]          qq_reg;
    logic [nlm_pkg::R_W-1:0]          r_reg;
    nlm_pkg::coef_t                   res_reg;

    logic [nlm_pkg::PROD_W-1:0]       p_w;
    logic [2*nlm_pkg::MU_W-1:0]       t_w;
    logic [nlm_pkg::MU_W-1:0]         q_w;
    logic [2*nlm_pkg::MU_W-1:0]       qq_w;
    logic [nlm_pkg::R_W-1:0]          r1_w;
    logic [nlm_pkg::R_W-1:0]          r2_w;

    // stage arithmetic
    always_comb
    begin
        p_w  = nlm_pkg::PROD_W'(x) * nlm_pkg::PROD_W'(y);
        t_w  = (2*nlm_pkg::MU_W)'(p_reg[nlm_pkg::PROD_W-1 -: nlm_pkg::MU_W])
             * (2*nlm_pkg::MU_W)'(nlm_pkg::MU);
        q_w  = t_reg[2*nlm_pkg::MU_W-1 -: nlm_pkg::MU_W];
        qq_w = (2*nlm_pkg::MU_W)'(q_w) * (2*nlm_pkg::MU_W)'(nlm_pkg::MODULUS);
        r1_w = (r_reg >= nlm_pkg::R_W'(nlm_pkg::MODULUS))
             ? r_reg - nlm_pkg::R_W'(nlm_pkg::MODULUS) : r_reg;
        r2_w = (r1_w >= nlm_pkg::R_W'(nlm_pkg::MODULUS))
             ? r1_w - nlm_pkg::R_W'(nlm_pkg::MODULUS) : r1_w;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        p_reg   <= p_w;
        t_reg   <= t_w;
        p2_reg  <= p_reg[nlm_pkg::R_W-1:0];
        qq_reg  <= qq_w[nlm_pkg::R_W-1:0];
        p3_reg  <= p2_reg;
        r_reg   <= p3_reg - qq_reg;
        res_reg <= r2_w[nlm_pkg::COEF_W-1:0];
    end

    assign done = vld_reg[4];
    assign res  = res_reg;

endmodule

FILE: hw/rtl/nlm_datapath.sv
// coefficient stores, butterfly arithmetic, multiplier and limb output registers
module nlm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nlm_pkg::dp_cmd_t              cmd,
    output nlm_pkg::dp_stat_t             stat,
    input  nlm_pkg::coef_t                a_coef,
    input  nlm_pkg::coef_t                b_coef,
    output logic                          result_valid,
    output logic [nlm_pkg::LIMB_W-1:0]    product_limb,
    output logic [nlm_pkg::CARRY_W-1:0]   carry_out,
    output logic                          result_last
);

    nlm_pkg::coef_t mem_a [nlm_pkg::N];
    nlm_pkg::coef_t mem_b [nlm_pkg::N];

    nlm_pkg::coef_t rd_a0_reg;
    nlm_pkg::coef_t rd_a1_reg;
    nlm_pkg::coef_t rd_b0_reg;
    nlm_pkg::coef_t rd_b1_reg;
    nlm_pkg::coef_t sum_reg;
    nlm_pkg::coef_t diff_reg;

    logic                          strobe_reg;
    logic                          last_reg;
    logic [nlm_pkg::LIMB_W-1:0]    limb_reg;
    logic [nlm_pkg::CARRY_W-1:0]   carry_reg;
    logic [nlm_pkg::ACC_W-1:0]     acc_reg;
    logic [nlm_pkg::ACC_W-1:0]     acc_next;

    nlm_pkg::coef_t red_a;
    nlm_pkg::coef_t red_b;
    nlm_pkg::coef_t wdata_a;
    nlm_pkg::coef_t wdata_b;
    nlm_pkg::coef_t u_w;
    nlm_pkg::coef_t v_w;
    logic [nlm_pkg::COEF_W:0] sum_w;
    logic [nlm_pkg::COEF_W:0] diff_w;
    nlm_pkg::coef_t sum_red;
    nlm_pkg::coef_t tw_w;
    nlm_pkg::coef_t mul_x;
    nlm_pkg::coef_t mul_y;
    nlm_pkg::coef_t mul_res;
    logic           mul_done;
    logic [nlm_pkg::COEF_W:0] t_w;

    // load reduction: inputs stay below twice the modulus
    always_comb
    begin
        red_a = (a_coef >= nlm_pkg::COEF_W'(nlm_pkg::MODULUS))
              ? a_coef - nlm_pkg::COEF_W'(nlm_pkg::MODULUS) : a_coef;
        red_b = (b_coef >= nlm_pkg::COEF_W'(nlm_pkg::MODULUS))
              ? b_coef - nlm_pkg::COEF_W'(nlm_pkg::MODULUS) : b_coef;
    end

    // store write data
    always_comb
    begin
        case (cmd.wr_src)
            nlm_pkg::WSRC_LOAD:
            begin
                wdata_a = red_a;
                wdata_b = red_b;
            end
            nlm_pkg::WSRC_ZERO:
            begin
                wdata_a = '0;
                wdata_b = '0;
            end
            nlm_pkg::WSRC_SUM:
            begin
                wdata_a = sum_reg;
                wdata_b = sum_reg;
            end
            default:
            begin
                wdata_a = mul_res;
                wdata_b = mul_res;
            end
        endcase
    end

    // coefficient stores, one write and two registered reads each
    always_ff @(posedge clk)
    begin
        if (cmd.we_a)
        begin
            mem_a[cmd.wr_addr] <= wdata_a;
        end
        if (cmd.we_b)
        begin
            mem_b[cmd.wr_addr] <= wdata_b;
        end
        rd_a0_reg <= mem_a[cmd.rd_addr0];
        rd_a1_reg <= mem_a[cmd.rd_addr1];
        rd_b0_reg <= mem_b[cmd.rd_addr0];
        rd_b1_reg <= mem_b[cmd.rd_addr1];
    end

    // butterfly add and subtract mod q
    always_comb
    begin
        u_w     = cmd.sel_b ? rd_b0_reg : rd_a0_reg;
        v_w     = cmd.sel_b ? rd_b1_reg : rd_a1_reg;
        sum_w   = {1'b0, u_w} + {1'b0, v_w};
        sum_red = (sum_w >= (nlm_pkg::COEF_W+1)'(nlm_pkg::MODULUS))
                ? nlm_pkg::COEF_W'(sum_w - (nlm_pkg::COEF_W+1)'(nlm_pkg::MODULUS))
                : sum_w[nlm_pkg::COEF_W-1:0];
        diff_w  = (u_w >= v_w)
                ? {1'b0, u_w} - {1'b0, v_w}
                : {1'b0, u_w} + (nlm_pkg::COEF_W+1)'(nlm_pkg::MODULUS) - {1'b0, v_w};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bf_latch)
        begin
            sum_reg  <= sum_red;
            diff_reg <= diff_w[nlm_pkg::COEF_W-1:0];
        end
    end

    // multiplier operand select
    always_comb
    begin
        tw_w = cmd.tw_inv ? nlm_pkg::INV_ROOTS[cmd.tw_idx] : nlm_pkg::FWD_ROOTS[cmd.tw_idx];
        case (cmd.mul_op)
            nlm_pkg::MOP_BFLY:
            begin
                mul_x = diff_reg;
                mul_y = tw_w;
            end
            nlm_pkg::MOP_POINT:
            begin
                mul_x = rd_a0_reg;
                mul_y = rd_b0_reg;
            end
            nlm_pkg::MOP_SCALE:
            begin
                mul_x = rd_a0_reg;
                mul_y = nlm_pkg::NINV;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    nlm_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign stat.mul_done = mul_done;

    // carry propagation
    always_comb
    begin
        t_w      = {1'b0, mul_res} + (nlm_pkg::COEF_W+1)'(acc_reg);
        acc_next = t_w[nlm_pkg::COEF_W -: nlm_pkg::ACC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.emit)
            begin
                acc_reg <= cmd.emit_last ? '0 : acc_next;
            end
        end
    end

    // limb output transaction registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            limb_reg  <= t_w[nlm_pkg::LIMB_W-1:0];
            carry_reg <= cmd.emit_last ? nlm_pkg::CARRY_W'(acc_next) : '0;
            last_reg  <= cmd.emit_last;
        end
    end

    assign result_valid = strobe_reg;
    assign product_limb = limb_reg;
    assign carry_out    = carry_reg;
    assign result_last  = last_reg;

endmodule

FILE: hw/rtl/nlm_controller.sv
// sequencer for load, zero fill, three transforms, pointwise pass and limb output
`include "ntt_limb_multiplier_defines.svh"

module nlm_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last,
    output logic              busy,
    output nlm_pkg::dp_cmd_t  cmd,
    input  nlm_pkg::dp_stat_t stat
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_FILL     = 14'b00000000000010,
        ST_BF_RD    = 14'b00000000000100,
        ST_BF_ADD   = 14'b00000000001000,
        ST_BF_MUL   = 14'b00000000010000,
        ST_BF_WAIT  = 14'b00000000100000,
        ST_PW_RD    = 14'b00000001000000,
        ST_PW_MUL   = 14'b00000010000000,
        ST_PW_WAIT  = 14'b00000100000000,
        ST_OUT_RD   = 14'b00001000000000,
        ST_OUT_MUL  = 14'b00010000000000,
        ST_OUT_WAIT = 14'b00100000000000,
        ST_SPARE_A  = 14'b01000000000000,
        ST_SPARE_B  = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PASS_A    = 2'd0,
        PASS_B    = 2'd1,
        PASS_PROD = 2'd2
    } pass_t;

    state_t                         state_reg, state_next;
    pass_t                          pass_reg, pass_next;
    logic [nlm_pkg::CNT_W-1:0]      load_cnt_reg, load_cnt_next;
    logic [nlm_pkg::BF_W-1:0]       bfc_reg, bfc_next;
    logic [nlm_pkg::STG_W-1:0]      stage_reg, stage_next;
    logic [nlm_pkg::ADDR_W-1:0]     idx_reg, idx_next;

    logic [nlm_pkg::STG_W-1:0]      half_log;
    logic [nlm_pkg::ADDR_W-1:0]     lo_mask;
    logic [nlm_pkg::ADDR_W-1:0]     bf_ext;
    logic [nlm_pkg::ADDR_W-1:0]     lowp;
    logic [nlm_pkg::ADDR_W-1:0]     j_w;
    logic [nlm_pkg::ADDR_W-1:0]     jh_w;
    logic [nlm_pkg::ADDR_W-1:0]     j_phys;
    logic [nlm_pkg::ADDR_W-1:0]     jh_phys;
    logic [nlm_pkg::CNT_W-1:0]      cnt_after;
    logic                           last_bfly_of_stage;
    logic                           last_stage;

    // butterfly index decode
    always_comb
    begin
        half_log = nlm_pkg::STG_W'(nlm_pkg::LOG_N - 1) - stage_reg;
        lo_mask  = (nlm_pkg::ADDR_W'(1) << half_log) - nlm_pkg::ADDR_W'(1);
        bf_ext   = {1'b0, bfc_reg};
        lowp     = bf_ext & lo_mask;
        j_w      = ((bf_ext & ~lo_mask) << 1) | lowp;
        jh_w     = j_w | (nlm_pkg::ADDR_W'(1) << half_log);
        // product pass works on bit-reversed physical positions
        j_phys   = (pass_reg == PASS_PROD) ? nlm_pkg::bit_rev(j_w) : j_w;
        jh_phys  = (pass_reg == PASS_PROD) ? nlm_pkg::bit_rev(jh_w) : jh_w;
        last_bfly_of_stage = (bfc_reg == nlm_pkg::BF_W'(nlm_pkg::N / 2 - 1));
        last_stage         = (stage_reg == nlm_pkg::STG_W'(nlm_pkg::LOG_N - 1));
        cnt_after = (load_cnt_reg < nlm_pkg::CNT_W'(nlm_pkg::N))
                  ? load_cnt_reg + nlm_pkg::CNT_W'(1) : load_cnt_reg;
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        load_cnt_next = load_cnt_reg;
        bfc_next      = bfc_reg;
        stage_next    = stage_reg;
        idx_next      = idx_reg;

        cmd           = '0;
        cmd.wr_src    = nlm_pkg::WSRC_LOAD;
        cmd.mul_op    = nlm_pkg::MOP_BFLY;
        cmd.sel_b     = (pass_reg == PASS_B);
        cmd.tw_inv    = (pass_reg != PASS_PROD);
        cmd.tw_idx    = lowp << stage_reg;
        cmd.rd_addr0  = idx_reg;
        cmd.rd_addr1  = idx_reg;
        cmd.wr_addr   = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_addr = load_cnt_reg[nlm_pkg::ADDR_W-1:0];
                if (start)
                begin
                    if (load_cnt_reg < nlm_pkg::CNT_W'(nlm_pkg::N))
                    begin
                        cmd.we_a = 1'b1;
                        cmd.we_b = 1'b1;
                    end
                    load_cnt_next = cnt_after;
                    if (last)
                    begin
                        if (cnt_after < nlm_pkg::CNT_W'(nlm_pkg::N))
                        begin
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            load_cnt_next = '0;
                            pass_next     = PASS_A;
                            stage_next    = '0;
                            bfc_next      = '0;
                            state_next    = ST_BF_RD;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                cmd.wr_addr   = load_cnt_reg[nlm_pkg::ADDR_W-1:0];
                cmd.wr_src    = nlm_pkg::WSRC_ZERO;
                cmd.we_a      = 1'b1;
                cmd.we_b      = 1'b1;
                load_cnt_next = load_cnt_reg + nlm_pkg::CNT_W'(1);
                if (load_cnt_reg == nlm_pkg::CNT_W'(nlm_pkg::N - 1))
                begin
                    load_cnt_next = '0;
                    pass_next     = PASS_A;
                    stage_next    = '0;
                    bfc_next      = '0;
                    state_next    = ST_BF_RD;
                end
            end
            ST_BF_RD:
            begin
                cmd.rd_addr0 = j_phys;
                cmd.rd_addr1 = jh_phys;
                state_next   = ST_BF_ADD;
            end
            ST_BF_ADD:
            begin
                cmd.rd_addr0 = j_phys;
                cmd.rd_addr1 = jh_phys;
                cmd.bf_latch = 1'b1;
                state_next   = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                // sum goes back to the lower position while the difference is multiplied
                cmd.mul_start = 1'b1;
                cmd.wr_addr   = j_phys;
                cmd.wr_src    = nlm_pkg::WSRC_SUM;
                cmd.we_a      = (pass_reg != PASS_B);
                cmd.we_b      = (pass_reg == PASS_B);
                state_next    = ST_BF_WAIT;
            end
            ST_BF_WAIT:
            begin
                cmd.wr_addr = jh_phys;
                cmd.wr_src  = nlm_pkg::WSRC_MUL;
                if (stat.mul_done)
                begin
                    cmd.we_a   = (pass_reg != PASS_B);
                    cmd.we_b   = (pass_reg == PASS_B);
                    state_next = ST_BF_RD;
                    bfc_next   = bfc_reg + nlm_pkg::BF_W'(1);
                    if (last_bfly_of_stage)
                    begin
                        stage_next = stage_reg + nlm_pkg::STG_W'(1);
                        if (last_stage)
                        begin
                            stage_next = '0;
                            idx_next   = '0;
                            case (pass_reg)
                                PASS_A:
                                begin
                                    pass_next = PASS_B;
                                end
                                PASS_B:
                                begin
                                    state_next = ST_PW_RD;
                                end
                                default:
                                begin
                                    state_next = ST_OUT_RD;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_PW_RD:
            begin
                state_next = ST_PW_MUL;
            end
            ST_PW_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = nlm_pkg::MOP_POINT;
                state_next    = ST_PW_WAIT;
            end
            ST_PW_WAIT:
            begin
                cmd.wr_src = nlm_pkg::WSRC_MUL;
                if (stat.mul_done)
                begin
                    cmd.we_a   = 1'b1;
                    idx_next   = idx_reg + nlm_pkg::ADDR_W'(1);
                    state_next = ST_PW_RD;
                    if (idx_reg == nlm_pkg::ADDR_W'(nlm_pkg::N - 1))
                    begin
                        pass_next  = PASS_PROD;
                        stage_next = '0;
                        bfc_next   = '0;
                        state_next = ST_BF_RD;
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = nlm_pkg::MOP_SCALE;
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (stat.mul_done)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = (idx_reg == nlm_pkg::ADDR_W'(nlm_pkg::N - 1));
                    idx_next      = idx_reg + nlm_pkg::ADDR_W'(1);
                    state_next    = cmd.emit_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pass_reg     <= PASS_A;
            load_cnt_reg <= '0;
            bfc_reg      <= '0;
            stage_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            load_cnt_reg <= load_cnt_next;
            bfc_reg      <= bfc_next;
            stage_reg    <= stage_next;
            idx_reg      <= idx_next;
        end
    end

    `NLM_ASSERT(a_cnt_range, load_cnt_reg <= nlm_pkg::CNT_W'(nlm_pkg::N), "load count past length")
    `NLM_ASSERT_NEXT(a_last_busy, start && !busy && last, busy, "last transaction did not start multiply")
    `NLM_ASSERT_IMPL(a_emit_done, cmd.emit, stat.mul_done, "limb emitted without multiplier result")
    `NLM_ASSERT_IMPL(a_start_idle_mul, cmd.mul_start, !stat.mul_done, "multiply started over a pending result")

endmodule

FILE: hw/rtl/ntt_limb_multiplier.sv
// top level of the ntt limb multiplier: controller and datapath
//
// Coefficient pairs are loaded one transaction per cycle while busy is low; a
// pair with last high starts the multiply, and positions not loaded read as
// zero. The multiply runs one butterfly at a time through a single five-stage
// barrett multiplier: the zero fill when needed, the transforms of a and b, the
// pointwise pass, the transform of the product and the output pass, each
// butterfly or coefficient waiting for the multiplier result before the next
// one starts. Results appear as N one-cycle transactions on result_valid, lowest
// limb first, and the receiver cannot stall them; carry_out is nonzero only on
// the transaction with result_last high. busy stays high from last until the
// final limb is issued.
module ntt_limb_multiplier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [nlm_pkg::COEF_W-1:0]    a_coef,
    input  logic [nlm_pkg::COEF_W-1:0]    b_coef,
    input  logic                          last,
    output logic                          result_valid,
    output logic [nlm_pkg::LIMB_W-1:0]    product_limb,
    output logic [nlm_pkg::CARRY_W-1:0]   carry_out,
    output logic                          result_last
);

    nlm_pkg::dp_cmd_t  cmd;
    nlm_pkg::dp_stat_t stat;

    nlm_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    nlm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .a_coef       (a_coef),
        .b_coef       (b_coef),
        .result_valid (result_valid),
        .product_limb (product_limb),
        .carry_out    (carry_out),
        .result_last  (result_last)
    );

endmodule

FILE: tb/sv/ntt_limb_checker.sv
// transaction monitor, product predictor and limb comparator for the ntt limb multiplier
module ntt_limb_checker
    import nlm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [COEF_W-1:0]  a_coef,
    input  logic [COEF_W-1:0]  b_coef,
    input  logic               last,
    input  logic               result_valid,
    input  logic [LIMB_W-1:0]  product_limb,
    input  logic [CARRY_W-1:0] carry_out,
    input  logic               result_last,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [LIMB_W-1:0]  limb;
        logic [CARRY_W-1:0] carry;
        logic               fin;
    } limb_t;

    localparam longint unsigned QW = longint'(MODULUS);

    longint unsigned pow_up [N];
    longint unsigned pow_dn [N];
    longint unsigned n_recip;
    longint unsigned held_a [N];
    longint unsigned held_b [N];
    int              pairs_held;
    limb_t           limb_queue [$];

    function automatic longint unsigned mmul(longint unsigned x, longint unsigned y);
        return (x * y) % QW;
    endfunction

    function automatic longint unsigned mpow(longint unsigned x, longint unsigned e);
        longint unsigned r;
        r = 1;
        while (e != 0)
        begin
            if (e[0])
            begin
                r = mmul(r, x);
            end
            x = mmul(x, x);
            e = e >> 1;
        end
        return r;
    endfunction

    // dif butterflies followed by index bit reversal
    function automatic void ntt_dif(ref longint unsigned x [N], ref longint unsigned tw [N]);
        longint unsigned u;
        longint unsigned v;
        longint unsigned t;
        int              stride;
        int              r;
        stride = 1;
        for (int half = N / 2; half >= 1; half = half / 2)
        begin
            for (int i = 0; i < half; i++)
            begin
                for (int j = i; j + half < N; j += 2 * half)
                begin
                    u = x[j];
                    v = x[j + half];
                    x[j] = (u + v) % QW;
                    x[j + half] = mmul((u + QW - v) % QW, tw[(stride * i) % N]);
                end
            end
            stride = stride * 2;
        end
        for (int i = 0; i < N; i++)
        begin
            r = 0;
            for (int k = 0; k < LOG_N; k++)
            begin
                if (i & (1 << k))
                begin
                    r |= 1 << (LOG_N - 1 - k);
                end
            end
            if (i < r)
            begin
                t = x[i];
                x[i] = x[r];
                x[r] = t;
            end
        end
    endfunction

    // cyclic convolution of the held pairs, pushed as carry-propagated limbs
    function automatic void predict_product();
        longint unsigned pa [N];
        longint unsigned pb [N];
        longint unsigned acc;
        longint unsigned sum;
        limb_t           e;
        for (int i = 0; i < N; i++)
        begin
            pa[i] = (i < pairs_held) ? held_a[i] : 0;
            pb[i] = (i < pairs_held) ? held_b[i] : 0;
        end
        ntt_dif(pa, pow_dn);
        ntt_dif(pb, pow_dn);
        for (int i = 0; i < N; i++)
        begin
            pa[i] = mmul(pa[i], pb[i]);
        end
        ntt_dif(pa, pow_up);
        acc = 0;
        for (int i = 0; i < N; i++)
        begin
            sum = mmul(pa[i], n_recip) + acc;
            acc = sum >> LIMB_W;
            e.limb = sum[LIMB_W-1:0];
            e.fin = (i == N - 1);
            e.carry = e.fin ? acc[CARRY_W-1:0] : '0;
            limb_queue.push_back(e);
        end
    endfunction

    // root tables
    initial
    begin
        longint unsigned w;
        longint unsigned wi;
        w = mpow(longint'(GENERATOR), (QW - 1) / N);
        wi = mpow(w, QW - 2);
        pow_up[0] = 1;
        pow_dn[0] = 1;
        for (int i = 1; i < N; i++)
        begin
            pow_up[i] = mmul(pow_up[i - 1], w);
            pow_dn[i] = mmul(pow_dn[i - 1], wi);
        end
        n_recip = mpow(N, QW - 2);
    end

    assign outstanding = limb_queue.size();

    // input transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_held = 0;
        end
        else if (start && !busy)
        begin
            if (pairs_held < N)
            begin
                held_a[pairs_held] = longint'(a_coef) % QW;
                held_b[pairs_held] = longint'(b_coef) % QW;
                pairs_held = pairs_held + 1;
            end
            if (last)
            begin
                predict_product();
                pairs_held = 0;
            end
        end
    end

    // result transactions
    initial errors = 0;
    always @(posedge clk)
    begin
        limb_t e;
        if (rst_n && result_valid)
        begin
            if (limb_queue.size() == 0)
            begin
                $display("%0t: unexpected limb %h carry %h last %b", $time,
                         product_limb, carry_out, result_last);
                errors = errors + 1;
            end
            else
            begin
                e = limb_queue.pop_front();
                if (product_limb !== e.limb)
                begin
                    $display("%0t: product_limb expected %h actual %h", $time,
                             e.limb, product_limb);
                    errors = errors + 1;
                end
                if (carry_out !== e.carry)
                begin
                    $display("%0t: carry_out expected %h actual %h", $time,
                             e.carry, carry_out);
                    errors = errors + 1;
                end
                if (result_last !== e.fin)
                begin
                    $display("%0t: result_last expected %b actual %b", $time,
                             e.fin, result_last);
                    errors = errors + 1;
                end
            end
        end
    end
endmodule

FILE: tb/sv/testbench.sv
// stimulus and verdict for the ntt limb multiplier
module testbench;
    import nlm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [COEF_W-1:0]  a_coef;
    logic [COEF_W-1:0]  b_coef;
    logic               last;
    logic               result_valid;
    logic [LIMB_W-1:0]  product_limb;
    logic [CARRY_W-1:0] carry_out;
    logic               result_last;
    int                 errors;
    int                 outstanding;
    int                 sent;
    bit                 allow_gaps;

    localparam logic [COEF_W-1:0] Q_C = MODULUS[COEF_W-1:0];

    ntt_limb_multiplier u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .a_coef       (a_coef),
        .b_coef       (b_coef),
        .last         (last),
        .result_valid (result_valid),
        .product_limb (product_limb),
        .carry_out    (carry_out),
        .result_last  (result_last)
    );

    ntt_limb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .a_coef       (a_coef),
        .b_coef       (b_coef),
        .last         (last),
        .result_valid (result_valid),
        .product_limb (product_limb),
        .carry_out    (carry_out),
        .result_last  (result_last),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // one transaction, with an optional idle burst ahead of it
    task automatic send_pair(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                             input logic fin);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        a_coef <= a;
        b_coef <= b;
        last <= fin;
        forever
        begin
            @(negedge clk);
            if (!busy)
            begin
                break;
            end
        end
        @(posedge clk);
        sent = sent + 1;
    endtask

    // coefficient with frequent extremes and out-of-range values
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_W'(Q_C - 1);
            2: return COEF_W'($urandom_range(Q_C, (1 << COEF_W) - 1));
            default: return COEF_W'($urandom_range(0, (1 << COEF_W) - 1));
        endcase
    endfunction

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int pairs;
        rst_n = 1'b0;
        start = 1'b0;
        a_coef = '0;
        b_coef = '0;
        last = 1'b0;
        sent = 0;
        allow_gaps = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single pair at the top of the input range
        send_pair('1, '1, 1'b1);
        // short load with extremes and unreduced coefficients
        send_pair(Q_C - 1, Q_C - 1, 1'b0);
        send_pair('0, '0, 1'b0);
        send_pair(Q_C, 30'd1, 1'b0);
        send_pair(30'd1, Q_C, 1'b1);
        // full load of maximal residues, largest carry
        for (int i = 0; i < N; i++)
        begin
            send_pair(Q_C - 1, Q_C - 1, i == N - 1);
        end

        // random sets: short, full and overfull loads
        while (sent < 400)
        begin
            if (sent > 350)
            begin
                allow_gaps = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: pairs = N;
                1: pairs = $urandom_range(N + 1, N + 8);
                default: pairs = $urandom_range(8, N - 1);
            endcase
            for (int i = 0; i < pairs; i++)
            begin
                send_pair(pick_coef(), pick_coef(), i == pairs - 1);
            end
        end
        start <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
